>>> design/ldist_pkg.sv
package ldist_pkg;

   localparam int unsigned MUL_STAGES = 3;
   localparam int unsigned DIV_STEPS  = 46;

   typedef logic signed [46:0] ldist_q_type;
   typedef logic signed [48:0] ldist_wide_type;
   typedef logic [45:0]        ldist_mag_type;

   typedef enum logic [2:0] {
      REG_K1,
      REG_K2,
      REG_K3,
      REG_K4,
      REG_K5,
      REG_K6,
      REG_P1,
      REG_P2
   } ldist_reg_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      ldist_q_type        xx;
      ldist_q_type        yy;
      ldist_q_type        xy;
      ldist_q_type        r2;
      ldist_q_type        tx;
      ldist_q_type        ty;
      ldist_q_type        acc_n;
      ldist_q_type        acc_d;
      ldist_q_type        dx;
      ldist_q_type        dy;
      logic               den_bad;
      logic               ovf;
   } ldist_side_type;

   typedef struct packed {
      logic signed [31:0] x_dist;
      logic signed [31:0] y_dist;
      logic               overflow;
   } ldist_res_type;

   localparam ldist_q_type    LIM_Q   = 47'sh3FFFFFFFFFFF;
   localparam ldist_q_type    ONE_Q   = 47'sh10000000;
   localparam ldist_wide_type LIM_W   = 49'sh3FFFFFFFFFFF;
   localparam ldist_wide_type OUT_MAX = 49'sh7FFFFFFF;
   localparam ldist_wide_type OUT_MIN = -49'sh80000000;

   function automatic ldist_mag_type mag_q(input ldist_q_type v);
      ldist_q_type n;
      n = v[46] ? -v : v;
      return n[45:0];
   endfunction

   function automatic ldist_q_type coef_q(input logic [31:0] k);
      return ldist_q_type'({{11{k[31]}}, k, 4'b0000});
   endfunction

   function automatic ldist_wide_type widen(input ldist_q_type v);
      return ldist_wide_type'(v);
   endfunction

   function automatic ldist_q_type sat_q(input ldist_wide_type v);
      if (v > LIM_W) return LIM_Q;
      if (v < -LIM_W) return -LIM_Q;
      return ldist_q_type'(v[46:0]);
   endfunction

   function automatic logic over_q(input ldist_wide_type v);
      return (v > LIM_W) || (v < -LIM_W);
   endfunction

   function automatic logic signed [31:0] out32(input ldist_wide_type v);
      if (v > OUT_MAX) return 32'sh7FFFFFFF;
      if (v < OUT_MIN) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic over32(input ldist_wide_type v);
      return (v > OUT_MAX) || (v < OUT_MIN);
   endfunction

endpackage

>>> design/ldist_req_if.sv
interface ldist_req_if;
   import ldist_pkg::*;
   logic               valid;
   logic               ready;
   logic signed [31:0] x_norm;
   logic signed [31:0] y_norm;
   modport source (output valid, output x_norm, output y_norm, input ready);
   modport sink (input valid, input x_norm, input y_norm, output ready);
endinterface

>>> design/ldist_rsp_if.sv
interface ldist_rsp_if;
   import ldist_pkg::*;
   logic               valid;
   logic               ready;
   logic signed [31:0] x_dist;
   logic signed [31:0] y_dist;
   logic               overflow;
   modport source (output valid, output x_dist, output y_dist, output overflow, input ready);
   modport sink (input valid, input x_dist, input y_dist, input overflow, output ready);
endinterface

>>> design/ldist_csr_if.sv
interface ldist_csr_if;
   import ldist_pkg::*;
   logic          valid;
   logic          ready;
   ldist_reg_type index;
   logic [31:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/ldist_mul.sv
module ldist_mul (
   input  logic                  clock,
   input  logic                  en,
   input  ldist_pkg::ldist_q_type a,
   input  ldist_pkg::ldist_q_type b,
   output ldist_pkg::ldist_q_type p,
   output logic                  ovf
);
   import ldist_pkg::*;

   ldist_mag_type ma;
   ldist_mag_type mb;
   logic [45:0]   pp00_ff;
   logic [45:0]   pp01_ff;
   logic [45:0]   pp10_ff;
   logic [45:0]   pp11_ff;
   logic          neg1_ff;
   logic [45:0]   lo_ff;
   logic [45:0]   hi_ff;
   logic [46:0]   mid_ff;
   logic          neg2_ff;
   logic [91:0]   full;
   logic [35:0]   pmag;
   logic          big;
   ldist_q_type   p_in;
   ldist_q_type   p_ff;
   logic          ovf_ff;

   assign ma = mag_q(a);
   assign mb = mag_q(b);

   always_comb begin
      full = {hi_ff, lo_ff} + {22'b0, mid_ff, 23'b0};
      big  = |full[91:64];
      pmag = full[63:28];
      if (big) begin
         p_in = neg2_ff ? -LIM_Q : LIM_Q;
      end else begin
         p_in = neg2_ff ? -ldist_q_type'({11'b0, pmag}) : ldist_q_type'({11'b0, pmag});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp00_ff <= ma[22:0] * mb[22:0];
         pp01_ff <= ma[22:0] * mb[45:23];
         pp10_ff <= ma[45:23] * mb[22:0];
         pp11_ff <= ma[45:23] * mb[45:23];
         neg1_ff <= a[46] ^ b[46];
         lo_ff   <= pp00_ff;
         hi_ff   <= pp11_ff;
         mid_ff  <= {1'b0, pp01_ff} + {1'b0, pp10_ff};
         neg2_ff <= neg1_ff;
         p_ff    <= p_in;
         ovf_ff  <= big;
      end
   end

   assign p   = p_ff;
   assign ovf = ovf_ff;
endmodule

>>> design/ldist_delay.sv
module ldist_delay (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  ldist_pkg::ldist_side_type in_side,
   output logic                     out_valid,
   output ldist_pkg::ldist_side_type out_side
);
   import ldist_pkg::*;

   logic           v_ff    [0:MUL_STAGES-1];
   ldist_side_type side_ff [0:MUL_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MUL_STAGES; k++) v_ff[k] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < MUL_STAGES; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int k = 1; k < MUL_STAGES; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   assign out_valid = v_ff[MUL_STAGES-1];
   assign out_side  = side_ff[MUL_STAGES-1];
endmodule

>>> design/ldist_div.sv
module ldist_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  ldist_pkg::ldist_side_type in_side,
   output logic                     out_valid,
   output ldist_pkg::ldist_side_type out_side,
   output ldist_pkg::ldist_q_type    quot
);
   import ldist_pkg::*;

   logic           v_ff    [0:DIV_STEPS];
   ldist_side_type side_ff [0:DIV_STEPS];
   logic [45:0]    rem_ff  [0:DIV_STEPS];
   logic [45:0]    dvd_ff  [0:DIV_STEPS];
   logic [45:0]    q_ff    [0:DIV_STEPS];
   logic [45:0]    md_ff   [0:DIV_STEPS];
   logic           neg_ff  [0:DIV_STEPS];
   logic           sat_ff  [0:DIV_STEPS];
   logic [45:0]    rem_in  [1:DIV_STEPS];
   logic           bit_in  [1:DIV_STEPS];

   logic           bad;
   ldist_mag_type  mn;
   logic [45:0]    md;
   logic           sat_in;
   ldist_side_type side0_in;
   logic           vo_ff;
   ldist_side_type so_in;
   ldist_side_type so_ff;
   ldist_q_type    quot_in;
   ldist_q_type    quot_ff;

   always_comb begin
      bad    = in_side.acc_d[46] || (in_side.acc_d == '0);
      md     = bad ? 46'd1 : in_side.acc_d[45:0];
      mn     = mag_q(in_side.acc_n);
      sat_in = !bad && ({18'b0, mn} >= {md, 18'b0});
      side0_in         = in_side;
      side0_in.den_bad = bad;
   end

   always_comb begin
      for (int k = 1; k <= DIV_STEPS; k++) begin
         logic [46:0] t;
         logic [46:0] d;
         t = {rem_ff[k-1], dvd_ff[k-1][45]};
         d = t - {1'b0, md_ff[k-1]};
         bit_in[k] = t >= {1'b0, md_ff[k-1]};
         rem_in[k] = bit_in[k] ? d[45:0] : t[45:0];
      end
   end

   always_comb begin
      if (sat_ff[DIV_STEPS]) begin
         quot_in = neg_ff[DIV_STEPS] ? -LIM_Q : LIM_Q;
      end else begin
         quot_in = neg_ff[DIV_STEPS] ? -ldist_q_type'({1'b0, q_ff[DIV_STEPS]})
                                     : ldist_q_type'({1'b0, q_ff[DIV_STEPS]});
      end
   end

   always_comb begin
      so_in     = side_ff[DIV_STEPS];
      so_in.ovf = side_ff[DIV_STEPS].ovf | sat_ff[DIV_STEPS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STEPS; k++) v_ff[k] <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k <= DIV_STEPS; k++) v_ff[k] <= v_ff[k-1];
         vo_ff <= v_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side0_in;
         rem_ff[0]  <= {18'b0, mn[45:18]};
         dvd_ff[0]  <= {mn[17:0], 28'b0};
         q_ff[0]    <= '0;
         md_ff[0]   <= md;
         neg_ff[0]  <= in_side.acc_n[46];
         sat_ff[0]  <= sat_in;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            side_ff[k] <= side_ff[k-1];
            rem_ff[k]  <= rem_in[k];
            dvd_ff[k]  <= {dvd_ff[k-1][44:0], 1'b0};
            q_ff[k]    <= {q_ff[k-1][44:0], bit_in[k]};
            md_ff[k]   <= md_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            sat_ff[k]  <= sat_ff[k-1];
         end
         so_ff     <= so_in;
         quot_ff   <= quot_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_side  = so_ff;
   assign quot      = quot_ff;
endmodule

>>> design/ldist_obuf.sv
module ldist_obuf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  ldist_pkg::ldist_res_type in_res,
   output logic                    space,
   ldist_rsp_if.source             rsp_ch
);
   import ldist_pkg::*;

   ldist_res_type mem_ff [0:1];
   logic [1:0]    count_ff;
   logic          wr_ff;
   logic          rd_ff;
   logic          push;
   logic          pop;
   ldist_res_type head;

   assign space  = count_ff != 2'd2;
   assign push   = in_valid && space;
   assign pop    = rsp_ch.valid && rsp_ch.ready;
   assign head   = mem_ff[rd_ff];

   assign rsp_ch.valid    = count_ff != 2'd0;
   assign rsp_ch.x_dist   = head.x_dist;
   assign rsp_ch.y_dist   = head.y_dist;
   assign rsp_ch.overflow = head.overflow;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         if (push && !pop) count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_res;
   end
endmodule

>>> design/lens_distortion_apply_core.sv
// Throughput: one word per cycle while the output queue has space; the 46-step restoring divider is fully pipelined.
// A two-word output queue keeps req ready while one result waits; the pipe stalls as a whole.
// Reset (synchronous, active high) clears all coefficients to zero and empties the pipe.
module lens_distortion_apply_core (
   input  logic        clock,
   input  logic        reset,
   ldist_req_if.sink   req_ch,
   ldist_rsp_if.source rsp_ch,
   ldist_csr_if.sink   csr_ch
);
   import ldist_pkg::*;

   logic [31:0]    coef_ff [0:7];
   logic           en;

   logic           v0_ff;
   ldist_side_type side0_in, side0_ff;
   ldist_q_type    xq0, yq0;

   ldist_q_type    m_xx, m_yy, m_xy;
   logic           o_xx, o_yy, o_xy;
   logic           v3;
   ldist_side_type side3;
   ldist_wide_type r2_sum;
   logic           v4_ff;
   ldist_side_type side4_in, side4_ff;

   ldist_q_type    m_n1, m_d1;
   logic           o_n1, o_d1;
   logic           v7;
   ldist_side_type side7;
   ldist_wide_type n1_sum, d1_sum, tx_sum, ty_sum;
   logic           v8_ff;
   ldist_side_type side8_in, side8_ff;

   ldist_q_type    m_n2, m_d2, m_p1xy, m_p2tx, m_p1ty, m_p2xy;
   logic           o_n2, o_d2, o_p1xy, o_p2tx, o_p1ty, o_p2xy;
   logic           v11;
   ldist_side_type side11;
   ldist_wide_type n2_sum, d2_sum, dx_sum, dy_sum;
   logic           v12_ff;
   ldist_side_type side12_in, side12_ff;

   ldist_q_type    m_n3, m_d3;
   logic           o_n3, o_d3;
   logic           v15;
   ldist_side_type side15;
   ldist_wide_type n3_sum, d3_sum;
   logic           v16_ff;
   ldist_side_type side16_in, side16_ff;

   logic           vd;
   ldist_side_type sided;
   ldist_q_type    quot;
   ldist_q_type    xqd, yqd;

   ldist_q_type    m_xs, m_ys;
   logic           o_xs, o_ys;
   logic           vf;
   ldist_side_type sidef;
   ldist_wide_type xo_sum, yo_sum;
   logic           vfin_ff;
   ldist_res_type  res_in, res_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 8; k++) coef_ff[k] <= '0;
      end else if (csr_ch.valid) begin
         coef_ff[csr_ch.index] <= csr_ch.data;
      end
   end

   assign req_ch.ready = en;

   always_comb begin
      side0_in   = '0;
      side0_in.x = req_ch.x_norm;
      side0_in.y = req_ch.y_norm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         v8_ff   <= 1'b0;
         v12_ff  <= 1'b0;
         v16_ff  <= 1'b0;
         vfin_ff <= 1'b0;
      end else if (en) begin
         v0_ff   <= req_ch.valid;
         v4_ff   <= v3;
         v8_ff   <= v7;
         v12_ff  <= v11;
         v16_ff  <= v15;
         vfin_ff <= vf;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side0_ff  <= side0_in;
         side4_ff  <= side4_in;
         side8_ff  <= side8_in;
         side12_ff <= side12_in;
         side16_ff <= side16_in;
         res_ff    <= res_in;
      end
   end

   assign xq0 = ldist_q_type'(side0_ff.x);
   assign yq0 = ldist_q_type'(side0_ff.y);

   ldist_mul u_mul_xx (.clock, .en, .a(xq0), .b(xq0), .p(m_xx), .ovf(o_xx));
   ldist_mul u_mul_yy (.clock, .en, .a(yq0), .b(yq0), .p(m_yy), .ovf(o_yy));
   ldist_mul u_mul_xy (.clock, .en, .a(xq0), .b(yq0), .p(m_xy), .ovf(o_xy));
   ldist_delay u_dly_sq (.clock, .reset, .en, .in_valid(v0_ff), .in_side(side0_ff),
                         .out_valid(v3), .out_side(side3));

   always_comb begin
      r2_sum        = widen(m_xx) + widen(m_yy);
      side4_in      = side3;
      side4_in.xx   = m_xx;
      side4_in.yy   = m_yy;
      side4_in.xy   = m_xy;
      side4_in.r2   = sat_q(r2_sum);
      side4_in.ovf  = side3.ovf | o_xx | o_yy | o_xy | over_q(r2_sum);
   end

   ldist_mul u_mul_n1 (.clock, .en, .a(side4_ff.r2), .b(coef_q(coef_ff[REG_K3])),
                       .p(m_n1), .ovf(o_n1));
   ldist_mul u_mul_d1 (.clock, .en, .a(side4_ff.r2), .b(coef_q(coef_ff[REG_K6])),
                       .p(m_d1), .ovf(o_d1));
   ldist_delay u_dly_h1 (.clock, .reset, .en, .in_valid(v4_ff), .in_side(side4_ff),
                         .out_valid(v7), .out_side(side7));

   always_comb begin
      n1_sum         = widen(coef_q(coef_ff[REG_K2])) + widen(m_n1);
      d1_sum         = widen(coef_q(coef_ff[REG_K5])) + widen(m_d1);
      tx_sum         = widen(side7.r2) + (widen(side7.xx) <<< 1);
      ty_sum         = widen(side7.r2) + (widen(side7.yy) <<< 1);
      side8_in       = side7;
      side8_in.acc_n = sat_q(n1_sum);
      side8_in.acc_d = sat_q(d1_sum);
      side8_in.tx    = sat_q(tx_sum);
      side8_in.ty    = sat_q(ty_sum);
      side8_in.ovf   = side7.ovf | o_n1 | o_d1 | over_q(n1_sum) | over_q(d1_sum)
                     | over_q(tx_sum) | over_q(ty_sum);
   end

   ldist_mul u_mul_n2 (.clock, .en, .a(side8_ff.r2), .b(side8_ff.acc_n),
                       .p(m_n2), .ovf(o_n2));
   ldist_mul u_mul_d2 (.clock, .en, .a(side8_ff.r2), .b(side8_ff.acc_d),
                       .p(m_d2), .ovf(o_d2));
   ldist_mul u_mul_p1xy (.clock, .en, .a(coef_q(coef_ff[REG_P1])), .b(side8_ff.xy),
                         .p(m_p1xy), .ovf(o_p1xy));
   ldist_mul u_mul_p2tx (.clock, .en, .a(coef_q(coef_ff[REG_P2])), .b(side8_ff.tx),
                         .p(m_p2tx), .ovf(o_p2tx));
   ldist_mul u_mul_p1ty (.clock, .en, .a(coef_q(coef_ff[REG_P1])), .b(side8_ff.ty),
                         .p(m_p1ty), .ovf(o_p1ty));
   ldist_mul u_mul_p2xy (.clock, .en, .a(coef_q(coef_ff[REG_P2])), .b(side8_ff.xy),
                         .p(m_p2xy), .ovf(o_p2xy));
   ldist_delay u_dly_h2 (.clock, .reset, .en, .in_valid(v8_ff), .in_side(side8_ff),
                         .out_valid(v11), .out_side(side11));

   always_comb begin
      n2_sum          = widen(coef_q(coef_ff[REG_K1])) + widen(m_n2);
      d2_sum          = widen(coef_q(coef_ff[REG_K4])) + widen(m_d2);
      dx_sum          = (widen(m_p1xy) <<< 1) + widen(m_p2tx);
      dy_sum          = widen(m_p1ty) + (widen(m_p2xy) <<< 1);
      side12_in       = side11;
      side12_in.acc_n = sat_q(n2_sum);
      side12_in.acc_d = sat_q(d2_sum);
      side12_in.dx    = sat_q(dx_sum);
      side12_in.dy    = sat_q(dy_sum);
      side12_in.ovf   = side11.ovf | o_n2 | o_d2 | o_p1xy | o_p2tx | o_p1ty | o_p2xy
                      | over_q(n2_sum) | over_q(d2_sum) | over_q(dx_sum) | over_q(dy_sum);
   end

   ldist_mul u_mul_n3 (.clock, .en, .a(side12_ff.r2), .b(side12_ff.acc_n),
                       .p(m_n3), .ovf(o_n3));
   ldist_mul u_mul_d3 (.clock, .en, .a(side12_ff.r2), .b(side12_ff.acc_d),
                       .p(m_d3), .ovf(o_d3));
   ldist_delay u_dly_h3 (.clock, .reset, .en, .in_valid(v12_ff), .in_side(side12_ff),
                         .out_valid(v15), .out_side(side15));

   always_comb begin
      n3_sum          = widen(ONE_Q) + widen(m_n3);
      d3_sum          = widen(ONE_Q) + widen(m_d3);
      side16_in       = side15;
      side16_in.acc_n = sat_q(n3_sum);
      side16_in.acc_d = sat_q(d3_sum);
      side16_in.ovf   = side15.ovf | o_n3 | o_d3 | over_q(n3_sum) | over_q(d3_sum);
   end

   ldist_div u_div (.clock, .reset, .en, .in_valid(v16_ff), .in_side(side16_ff),
                    .out_valid(vd), .out_side(sided), .quot(quot));

   assign xqd = ldist_q_type'(sided.x);
   assign yqd = ldist_q_type'(sided.y);

   ldist_mul u_mul_xs (.clock, .en, .a(xqd), .b(quot), .p(m_xs), .ovf(o_xs));
   ldist_mul u_mul_ys (.clock, .en, .a(yqd), .b(quot), .p(m_ys), .ovf(o_ys));
   ldist_delay u_dly_fin (.clock, .reset, .en, .in_valid(vd), .in_side(sided),
                          .out_valid(vf), .out_side(sidef));

   always_comb begin
      xo_sum = widen(m_xs) + widen(sidef.dx);
      yo_sum = widen(m_ys) + widen(sidef.dy);
      if (sidef.den_bad) begin
         res_in.x_dist   = '0;
         res_in.y_dist   = '0;
         res_in.overflow = 1'b1;
      end else begin
         res_in.x_dist   = out32(xo_sum);
         res_in.y_dist   = out32(yo_sum);
         res_in.overflow = sidef.ovf | o_xs | o_ys | over32(xo_sum) | over32(yo_sum);
      end
   end

   ldist_obuf u_obuf (.clock, .reset, .in_valid(vfin_ff && en), .in_res(res_ff),
                      .space(en), .rsp_ch(rsp_ch));
endmodule
